[sv/first_fit_block_allocator_assert.svh]
// Assertion macros used by the allocator controller.
// Each macro takes a label, a clock, a property body and a message; FFA_ASSERT also takes a reset term.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FFA_ASSERT(label, clk, dis, prop, msg) \
    label: assert property (@(posedge clk) disable iff (dis) prop) else $error(msg);
`define FFA_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFA_ASSERT(label, clk, dis, prop, msg)
`define FFA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[sv/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, status codes and commands of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int unsigned MAX_BLOCKS_DEF = 32;
    localparam int unsigned ADDR_BITS_DEF  = 16;
    localparam int unsigned SIZE_W         = 16;
    localparam int unsigned STATUS_W       = 3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FIT       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 3'd5;

    // Operation codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_INIT,
        CMD_LOAD,
        CMD_SCAN_START,
        CMD_SCAN_STEP,
        CMD_SPLIT,
        CMD_SHIFT_UP,
        CMD_MARK_FREE,
        CMD_MERGE_NEXT,
        CMD_MERGE_PREV,
        CMD_SHIFT_DOWN,
        CMD_RESULT
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic                func;
        logic                req_zero;
        logic                scan_end;
        logic                hit;
        logic                hit_free;
        logic                fits;
        logic                exact;
        logic                table_full;
        logic                shift_done;
        logic                next_free;
        logic                prev_free;
        logic                has_next;
        logic                has_prev;
    } t_dp_status;

endpackage

[sv/first_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over an ordered block table, one request at a time.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake       Word
// in       input      valid / stall   func, request_size, address
// out      output     valid / stall   status, block_address, free_total
// cfg      input      valid / ready   total_size
//
// An allocate scans to the first free block that fits; on a split the entries
// above it first move up to open a hole. A free scans to the block at the
// address, marks it free, then merges with a free next block and with a free
// previous block, moving the later entries down after each merge. A refused
// request ends at the scan.
// Synchronous reset gives one free block of 65535 units.
// A result holds while out stall is high; no new word is taken meanwhile.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
    import ffa_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_func,
    input  logic [SIZE_W-1:0]   i_request_size,
    input  logic [SIZE_W-1:0]   i_address,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [SIZE_W-1:0]   o_block_address,
    output logic [SIZE_W-1:0]   o_free_total,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [SIZE_W-1:0]   i_total_size
);

    t_cmd                cmd;
    t_dp_status          st;
    logic [STATUS_W-1:0] res_status;

    // Sequencer.
    ffa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cfg_ready  (o_cfg_ready),
        .i_st         (st),
        .o_cmd        (cmd),
        .o_res_status (res_status)
    );

    // Table and result datapath.
    ffa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_res_status    (res_status),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_total_size),
        .i_func          (i_func),
        .i_request_size  (i_request_size),
        .i_address       (i_address),
        .o_status        (st),
        .o_status_code   (o_status),
        .o_block_address (o_block_address),
        .o_free_total    (o_free_total)
    );

endmodule

[sv/ffa_datapath.sv]
// ----------------------------------------------------------------------------
// ffa_datapath
// Block table registers, scan index, shift engine and result registers.
// ----------------------------------------------------------------------------
module ffa_datapath
    import ffa_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [STATUS_W-1:0]     i_res_status,
    input  logic                    i_cfg_we,
    input  logic [SIZE_W-1:0]       i_cfg_data,
    input  logic                    i_func,
    input  logic [SIZE_W-1:0]       i_request_size,
    input  logic [SIZE_W-1:0]       i_address,
    output t_dp_status              o_status,
    output logic [STATUS_W-1:0]     o_status_code,
    output logic [SIZE_W-1:0]       o_block_address,
    output logic [SIZE_W-1:0]       o_free_total
);

    localparam int unsigned IDX_W     = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W     = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned ADDR_BITS = ADDR_BITS_DEF;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

    // Table storage: one register per entry, moved only to neighbors.
    logic [ADDR_BITS-1:0] r_start [MAX_BLOCKS];
    logic [SIZE_W-1:0]    r_size  [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_free;

    logic [CNT_W-1:0]     r_count;
    logic [SIZE_W-1:0]    r_free_units;
    logic [SIZE_W-1:0]    r_total;
    logic [CNT_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_sh;
    logic                 r_func;
    logic [SIZE_W-1:0]    r_req;
    logic [SIZE_W-1:0]    r_addr;
    logic [STATUS_W-1:0]  r_res_status;
    logic [SIZE_W-1:0]    r_res_addr;

    logic [IDX_W-1:0]     cur;
    logic [IDX_W-1:0]     nxt;
    logic [IDX_W-1:0]     prv;
    logic [IDX_W-1:0]     sh_i;
    logic [IDX_W-1:0]     sh_im1;
    logic [IDX_W-1:0]     sh_ip1;
    logic [ADDR_BITS-1:0] addr_ext;

    assign cur    = r_idx[IDX_W-1:0];
    assign nxt    = IDX_W'(r_idx + 1'b1);
    assign prv    = IDX_W'(r_idx - 1'b1);
    assign sh_i   = r_sh[IDX_W-1:0];
    assign sh_im1 = IDX_W'(r_sh - 1'b1);
    assign sh_ip1 = IDX_W'(r_sh + 1'b1);
    assign addr_ext = ADDR_BITS'(r_addr);

    // Status toward the controller.
    always_comb begin
        o_status.func       = r_func;
        o_status.req_zero   = (r_req == '0);
        o_status.scan_end   = (r_idx >= r_count);
        o_status.hit        = (r_start[cur] == addr_ext);
        o_status.hit_free   = r_free[cur];
        o_status.fits       = r_free[cur] && (r_size[cur] >= r_req);
        o_status.exact      = (r_size[cur] == r_req);
        o_status.table_full = (r_count >= CNT_MAX);
        o_status.has_next   = ((r_idx + 1'b1) < r_count);
        o_status.has_prev   = (r_idx != '0);
        o_status.next_free  = r_free[nxt];
        o_status.prev_free  = r_free[prv];
        o_status.shift_done = (r_func == FUNC_ALLOC) ? (r_sh <= r_idx + 1'b1)
                                                     : (r_sh + 1'b1 >= r_count);
    end

    assign o_status_code   = r_res_status;
    assign o_block_address = r_res_addr;
    assign o_free_total    = r_free_units;

    // Table, control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total      <= 16'hFFFF;
            r_count      <= CNT_W'(1);
            r_free_units <= 16'hFFFF;
            r_free       <= MAX_BLOCKS'(1);
            r_start[0]   <= '0;
            r_size[0]    <= 16'hFFFF;
            r_idx        <= '0;
            r_sh         <= '0;
        end else if (i_cfg_we) begin
            r_total      <= i_cfg_data;
            r_count      <= CNT_W'(1);
            r_free_units <= i_cfg_data;
            r_free       <= MAX_BLOCKS'(1);
            r_start[0]   <= '0;
            r_size[0]    <= i_cfg_data;
        end else begin
            case (i_cmd)
                CMD_INIT: begin
                    r_count      <= CNT_W'(1);
                    r_free_units <= r_total;
                    r_free       <= MAX_BLOCKS'(1);
                    r_start[0]   <= '0;
                    r_size[0]    <= r_total;
                end
                CMD_LOAD: begin
                    r_func <= i_func;
                    r_req  <= i_request_size;
                    r_addr <= i_address;
                end
                CMD_SCAN_START: r_idx <= '0;
                CMD_SCAN_STEP:  r_idx <= r_idx + 1'b1;
                // Open a hole at idx+1 by moving entries up, top first.
                CMD_SHIFT_UP: begin
                    if (r_sh > r_idx + 1'b1) begin
                        r_start[sh_i] <= r_start[sh_im1];
                        r_size[sh_i]  <= r_size[sh_im1];
                        r_free[sh_i]  <= r_free[sh_im1];
                        r_sh          <= r_sh - 1'b1;
                    end
                end
                // Allocate: shrink entry and, unless it fits exactly, write the remainder into the hole.
                CMD_SPLIT: begin
                    r_free[cur]       <= 1'b0;
                    r_size[cur]       <= r_req;
                    r_free_units      <= r_free_units - r_req;
                    r_res_addr        <= SIZE_W'(r_start[cur]);
                    if (r_size[cur] != r_req) begin
                        r_start[nxt] <= r_start[cur] + ADDR_BITS'(r_req);
                        r_size[nxt]  <= r_size[cur] - r_req;
                        r_free[nxt]  <= 1'b1;
                        r_count      <= r_count + 1'b1;
                    end
                    r_sh <= r_count;
                end
                CMD_MARK_FREE: begin
                    r_free[cur]  <= 1'b1;
                    r_free_units <= r_free_units + r_size[cur];
                    r_res_addr   <= r_addr;
                end
                CMD_MERGE_NEXT: begin
                    r_size[cur] <= r_size[cur] + r_size[nxt];
                    r_sh        <= r_idx + 1'b1;
                end
                CMD_MERGE_PREV: begin
                    r_size[prv] <= r_size[prv] + r_size[cur];
                    r_sh        <= r_idx;
                    r_idx       <= r_idx - 1'b1;
                end
                // Close the gap at r_sh by moving entries down.
                CMD_SHIFT_DOWN: begin
                    if (r_sh + 1'b1 < r_count) begin
                        r_start[sh_i] <= r_start[sh_ip1];
                        r_size[sh_i]  <= r_size[sh_ip1];
                        r_free[sh_i]  <= r_free[sh_ip1];
                        r_sh          <= r_sh + 1'b1;
                    end else begin
                        r_free[sh_i] <= 1'b0;
                        r_count      <= r_count - 1'b1;
                    end
                end
                // Latch the result status; a refused request reports address 0.
                CMD_RESULT: begin
                    r_res_status <= i_res_status;
                    if (i_res_status != ST_OK) r_res_addr <= '0;
                end
                default: ;
            endcase
            if (i_cmd == CMD_SCAN_START && r_func == FUNC_ALLOC) r_sh <= r_count;
        end
    end

endmodule

[sv/ffa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for scan, split, merge and the output handshake.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_assert.svh"
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_cfg_ready,
    input  t_dp_status          i_st,
    output t_cmd                o_cmd,
    output logic [STATUS_W-1:0] o_res_status
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_SCAN, S_SHIFT, S_SPLIT, S_MARK, S_MNEXT,
        S_MPREV, S_SDOWN, S_SDOWN2, S_RES, S_OUT
    } t_state;

    t_state              r_state, n_state;
    logic                r_out_valid;
    logic                r_prev_pend, n_prev_pend;
    logic [STATUS_W-1:0] r_res, n_res;
    t_cmd                cmd;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        n_prev_pend = r_prev_pend;
        n_res       = r_res;
        cmd         = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !r_out_valid) begin
                    cmd = CMD_LOAD;
                    n_state = S_START;
                end
            end
            S_START: begin
                cmd = CMD_SCAN_START;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_st.func == FUNC_ALLOC && i_st.req_zero) begin
                    n_res = ST_BAD_SIZE;
                    n_state = S_RES;
                end else if (i_st.scan_end) begin
                    n_res = (i_st.func == FUNC_ALLOC) ? ST_NO_FIT : ST_NO_BLOCK;
                    n_state = S_RES;
                end else if (i_st.func == FUNC_ALLOC) begin
                    if (i_st.fits) begin
                        if (!i_st.exact && i_st.table_full) begin
                            n_res = ST_TABLE_FULL;
                            n_state = S_RES;
                        end else begin
                            n_res = ST_OK;
                            n_state = i_st.exact ? S_SPLIT : S_SHIFT;
                        end
                    end else begin
                        cmd = CMD_SCAN_STEP;
                    end
                end else if (i_st.hit) begin
                    if (i_st.hit_free) begin
                        n_res = ST_ALREADY_FREE;
                        n_state = S_RES;
                    end else begin
                        n_res = ST_OK;
                        n_state = S_MARK;
                    end
                end else begin
                    cmd = CMD_SCAN_STEP;
                end
            end
            S_SHIFT: begin
                cmd = CMD_SHIFT_UP;
                if (i_st.shift_done) n_state = S_SPLIT;
            end
            S_SPLIT: begin
                cmd = CMD_SPLIT;
                n_state = S_RES;
            end
            S_MARK: begin
                cmd = CMD_MARK_FREE;
                n_state = S_MNEXT;
            end
            S_MNEXT: begin
                n_prev_pend = i_st.has_prev && i_st.prev_free;
                if (i_st.has_next && i_st.next_free) begin
                    cmd = CMD_MERGE_NEXT;
                    n_state = S_SDOWN;
                end else begin
                    n_state = S_MPREV;
                end
            end
            S_SDOWN: begin
                cmd = CMD_SHIFT_DOWN;
                if (i_st.shift_done) n_state = S_MPREV;
            end
            S_MPREV: begin
                if (r_prev_pend) begin
                    cmd = CMD_MERGE_PREV;
                    n_prev_pend = 1'b0;
                    n_state = S_SDOWN2;
                end else begin
                    n_state = S_RES;
                end
            end
            S_SDOWN2: begin
                cmd = CMD_SHIFT_DOWN;
                if (i_st.shift_done) n_state = S_RES;
            end
            S_RES: begin
                cmd = CMD_RESULT;
                n_state = S_OUT;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_prev_pend <= 1'b0;
            r_res       <= ST_OK;
        end else begin
            r_state     <= n_state;
            r_prev_pend <= n_prev_pend;
            r_res       <= n_res;
            if (r_state == S_RES) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // A configuration write waits until no request or result word is in flight.
    assign o_cmd        = cmd;
    assign o_res_status = r_res;
    assign o_in_stall   = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid  = r_out_valid;
    assign o_cfg_ready  = (r_state == S_IDLE) && !r_out_valid && !i_in_valid;

    `FFA_ASSERT(a_one_accept, i_clk, !i_rst_n, (i_in_valid && !o_in_stall) |=> (r_state == S_START), "accepted word did not start")
    `FFA_ASSERT(a_res_then_valid, i_clk, !i_rst_n, (r_state == S_RES) |=> r_out_valid, "result word not presented")
    `FFA_ASSERT(a_no_accept_busy, i_clk, !i_rst_n, r_out_valid |-> o_in_stall, "input taken while result pending")

endmodule
